FILE: hw/rtl/h4pd_pkg.sv
// ----------------------------------------------------------------------------
// h4pd_pkg
// Shared types and constants for the H4 packet deframer.
// ----------------------------------------------------------------------------
package h4pd_pkg;

    // H4 packet type bytes
    localparam logic [7:0] TYPE_CMD    = 8'h01;
    localparam logic [7:0] TYPE_ACL    = 8'h02;
    localparam logic [7:0] TYPE_SCO    = 8'h03;
    localparam logic [7:0] TYPE_EVT    = 8'h04;
    localparam logic [7:0] TYPE_VENDOR = 8'hff;

    // Stream widths
    localparam int unsigned DATA_W = 8;
    localparam int unsigned USER_W = 8;
    localparam int unsigned HPOS_W = 3;
    localparam int unsigned LEN_W  = 16;

    // Packet type code carried with every beat
    typedef enum logic [2:0] {
        PT_CMD    = 3'd0,
        PT_ACL    = 3'd1,
        PT_SCO    = 3'd2,
        PT_EVT    = 3'd3,
        PT_VENDOR = 3'd4
    } t_ptype;

    // What happened to a beat
    typedef enum logic [1:0] {
        KIND_FWD  = 2'd0,
        KIND_DROP = 2'd1,
        KIND_UNK  = 2'd2
    } t_kind;

    // Parser phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_VENDOR  = 2'd3
    } t_phase;

    // One result beat
    typedef struct packed {
        logic [DATA_W-1:0] data;
        t_kind             kind;
        logic              first;
        logic              last;
        t_ptype            ptype;
    } t_result;

    // Offset of the last header byte for a given packet type
    function automatic logic [HPOS_W-1:0] header_last(input t_ptype t);
        logic [HPOS_W-1:0] hl;
        begin
            hl = HPOS_W'(3);
            if (t == PT_ACL) begin
                hl = HPOS_W'(4);
            end else if (t == PT_EVT) begin
                hl = HPOS_W'(2);
            end
            return hl;
        end
    endfunction

endpackage

FILE: hw/rtl/h4pd_parser.sv
// ----------------------------------------------------------------------------
// h4pd_parser
// Packet boundary tracker: decodes one byte per step and updates the header
// position, length and payload counters.
// ----------------------------------------------------------------------------
module h4pd_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [h4pd_pkg::DATA_W-1:0]   i_byte,
    input  logic                          i_chunk_end,
    input  logic                          i_drop_vendor,
    output h4pd_pkg::t_result             o_result
);
    import h4pd_pkg::*;

    t_phase              r_phase,   n_phase;
    t_ptype              r_type,    n_type;
    logic [HPOS_W-1:0]   r_hpos,    n_hpos;
    logic [DATA_W-1:0]   r_len_lo,  n_len_lo;
    logic [LEN_W-1:0]    r_remain,  n_remain;

    logic [LEN_W-1:0]    w_len;
    logic [LEN_W-1:0]    w_remain_dec;
    t_kind               w_vendor_kind;

    assign w_vendor_kind = i_drop_vendor ? KIND_DROP : KIND_FWD;
    assign w_remain_dec  = r_remain - LEN_W'(1);
    // ACL length is little-endian; the high byte is the current one
    assign w_len = (r_type == PT_ACL) ? {i_byte, r_len_lo} : {{(LEN_W-DATA_W){1'b0}}, i_byte};

    // Next state and result for the current byte
    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_hpos   = r_hpos;
        n_len_lo = r_len_lo;
        n_remain = r_remain;

        o_result.data  = i_byte;
        o_result.kind  = KIND_FWD;
        o_result.first = 1'b0;
        o_result.last  = 1'b0;
        o_result.ptype = PT_CMD;

        unique case (r_phase)
            PH_IDLE: begin
                n_hpos = HPOS_W'(1);
                unique case (i_byte)
                    TYPE_CMD: begin
                        o_result.first = 1'b1;
                        o_result.ptype = PT_CMD;
                        n_type  = PT_CMD;
                        n_phase = PH_HEADER;
                    end
                    TYPE_ACL: begin
                        o_result.first = 1'b1;
                        o_result.ptype = PT_ACL;
                        n_type  = PT_ACL;
                        n_phase = PH_HEADER;
                    end
                    TYPE_SCO: begin
                        o_result.first = 1'b1;
                        o_result.ptype = PT_SCO;
                        n_type  = PT_SCO;
                        n_phase = PH_HEADER;
                    end
                    TYPE_EVT: begin
                        o_result.first = 1'b1;
                        o_result.ptype = PT_EVT;
                        n_type  = PT_EVT;
                        n_phase = PH_HEADER;
                    end
                    TYPE_VENDOR: begin
                        // type byte is never last, even at a chunk end
                        o_result.first = 1'b1;
                        o_result.ptype = PT_VENDOR;
                        o_result.kind  = w_vendor_kind;
                        n_type  = PT_VENDOR;
                        n_phase = PH_VENDOR;
                    end
                    default: begin
                        // unknown type: discard, stay idle to resync
                        o_result.kind = KIND_UNK;
                        n_hpos        = r_hpos;
                    end
                endcase
            end
            PH_HEADER: begin
                o_result.ptype = r_type;
                if (r_type == PT_ACL && r_hpos == HPOS_W'(3)) begin
                    n_len_lo = i_byte;
                end
                if (r_hpos >= header_last(r_type)) begin
                    n_remain = w_len;
                    n_hpos   = '0;
                    if (w_len == '0) begin
                        o_result.last = 1'b1;
                        n_phase       = PH_IDLE;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_hpos = r_hpos + HPOS_W'(1);
                end
            end
            PH_PAYLOAD: begin
                o_result.ptype = r_type;
                n_remain       = w_remain_dec;
                if (w_remain_dec == '0) begin
                    o_result.last = 1'b1;
                    n_phase       = PH_IDLE;
                end
            end
            PH_VENDOR: begin
                // vendor packet closes on the first chunk end
                o_result.ptype = PT_VENDOR;
                o_result.kind  = w_vendor_kind;
                if (i_chunk_end) begin
                    o_result.last = 1'b1;
                    n_phase       = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Parser state, advanced once per byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_type   <= PT_CMD;
            r_hpos   <= '0;
            r_len_lo <= '0;
            r_remain <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_hpos   <= n_hpos;
            r_len_lo <= n_len_lo;
            r_remain <= n_remain;
        end
    end

endmodule

FILE: hw/rtl/h4_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// h4_packet_deframer_unit
// H4 byte stream deframer: marks packet boundaries and tags each byte.
// ----------------------------------------------------------------------------
// One input beat is one stream byte, and every input beat yields exactly one
// output beat, at a sustained rate of one byte per clock while m_axis_tready
// stays high. A byte passes an input register, is parsed by the packet tracker
// and lands in an output register, from which it is offered on the master side;
// s_axis_tready follows m_axis_tready within the same cycle once both
// registers hold data. drop_vendor is written on the cfg channel, which is
// always ready, and should only change while no beat is in flight.
// ----------------------------------------------------------------------------
module h4_packet_deframer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,      // drop_vendor
    // byte stream in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [h4pd_pkg::DATA_W-1:0]   s_axis_tdata,    // [7:0] in_byte
    input  logic                          s_axis_tlast,    // chunk_end
    // tagged byte stream out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [h4pd_pkg::DATA_W-1:0]   m_axis_tdata,    // [7:0] out_byte
    output logic [h4pd_pkg::USER_W-1:0]   m_axis_tuser,    // [1:0] byte_kind,
                                                           // [2] first_of_packet,
                                                           // [5:3] packet_type,
                                                           // [7:6] zero
    output logic                          m_axis_tlast     // last_of_packet
);
    import h4pd_pkg::*;

    logic                r_drop_vendor;
    logic                r_in_valid;
    logic [DATA_W-1:0]   r_in_byte;
    logic                r_in_last;
    logic                r_out_valid;
    t_result             r_out;

    logic                w_out_free;
    logic                w_advance;
    t_result             w_result;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_vendor <= 1'b1;
        end else if (i_cfg_valid) begin
            r_drop_vendor <= i_cfg_data;
        end
    end

    // Pipeline flow control
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Packet tracker
    h4pd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_advance),
        .i_byte        (r_in_byte),
        .i_chunk_end   (r_in_last),
        .i_drop_vendor (r_drop_vendor),
        .o_result      (w_result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.data;
    assign m_axis_tuser  = {2'b00, r_out.ptype, r_out.first, r_out.kind};
    assign m_axis_tlast  = r_out.last;

endmodule

FILE: hw/rtl/h4pd_checker.sv
// ----------------------------------------------------------------------------
// h4pd_checker
// Port-level checks for the H4 packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
module h4pd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [h4pd_pkg::DATA_W-1:0]   m_axis_tdata,
    input  logic [h4pd_pkg::USER_W-1:0]   m_axis_tuser,
    input  logic                          m_axis_tlast
);
    import h4pd_pkg::*;

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // Nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // Discarded unknown byte carries no packet marks
    a_unknown_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == KIND_UNK
            |-> !m_axis_tuser[2] && !m_axis_tlast && m_axis_tuser[5:3] == PT_CMD)
        else $error("unknown byte carries packet marks");

    // Vendor type byte never closes its packet
    a_vendor_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] && m_axis_tuser[5:3] == PT_VENDOR
            |-> !m_axis_tlast)
        else $error("vendor packet closed on its type byte");

    // Only vendor bytes are dropped
    a_drop_vendor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == KIND_DROP
            |-> m_axis_tuser[5:3] == PT_VENDOR)
        else $error("dropped byte outside a vendor packet");

endmodule

bind h4_packet_deframer_unit h4pd_checker u_h4pd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
